FILE: hw/rtl/chained_hash_map_top_defines.svh
// Assertion macros for the chained hash map.
`ifndef CHAINED_HASH_MAP_TOP_DEFINES_SVH
`define CHAINED_HASH_MAP_TOP_DEFINES_SVH

// Condition holds in the same cycle as its trigger.
`define CHM_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("chained hash map check failed");

// Condition holds in the cycle after its trigger.
`define CHM_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("chained hash map check failed");

`endif

FILE: hw/rtl/chm_pkg.sv
package chm_pkg;

   localparam int BUCKETS      = 1024;
   localparam int POOL_ENTRIES = 256;
   localparam int KEY_BITS     = 32;
   localparam int VALUE_BITS   = 32;

   localparam int BUCKET_W   = $clog2(BUCKETS);
   localparam int POOL_W     = $clog2(POOL_ENTRIES);
   localparam int LINK_W     = $clog2(POOL_ENTRIES + 1);
   localparam int COUNT_W    = LINK_W;
   localparam int INIT_DEPTH = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
   localparam int INIT_W     = $clog2(INIT_DEPTH);
   localparam int INIT_CW    = INIT_W + 1;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } chm_command_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EXISTS    = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_KEY_ZERO  = 3'd4
   } chm_status_type;

   typedef struct packed {
      logic           init_step;
      logic           load_req;
      logic           head_rd;
      logic           head_take;
      logic           walk;
      logic           take_hit;
      logic           put_rd;
      logic           put_wr;
      logic           unlink;
      logic           rem_free;
      logic           rsp_load;
      chm_status_type rsp_code;
      logic           rsp_found;
   } chm_cmd_type;

   typedef struct packed {
      logic               init_done;
      chm_command_type    command;
      logic               key_zero;
      logic               head_nil;
      logic               key_match;
      logic               link_nil;
      logic               hit;
      logic               prev_nil;
      logic               free_nil;
      logic               rsp_busy;
      logic [COUNT_W-1:0] count;
   } chm_sts_type;

   function automatic logic is_nil(input logic [LINK_W-1:0] idx);
      return idx >= NIL;
   endfunction

   function automatic logic [LINK_W-1:0] clamp(input logic [LINK_W-1:0] idx);
      return is_nil(idx) ? NIL : idx;
   endfunction

endpackage

FILE: hw/rtl/chm_if.sv
interface chm_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [chm_pkg::KEY_BITS-1:0]   key;
   logic [chm_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, command, key, value, input ready);
   modport sink   (input valid, command, key, value, output ready);
endinterface

interface chm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [chm_pkg::VALUE_BITS-1:0] found_value;
   logic [chm_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

FILE: hw/rtl/chained_hash_map_top.sv
// channel  | dir | handshake     | payload
// req_bus  | in  | valid / ready | command[1:0], key[31:0], value[31:0]
// rsp_bus  | out | valid / ready | status[2:0], found_value[31:0], entry_count[8:0]
//
// One request at a time: from accept the block steps through lookup, head read and
// a walk over the chain entries to the result; a put that stores or a remove that
// unlinks adds an update step, and key zero or the unused command goes straight
// from lookup to the result. The walk follows the chain through the link/key RAM ports.
// After reset a clearing pass over all max(BUCKETS, POOL_ENTRIES) addresses (1024) empties
// the bucket heads and builds the free list; no request is taken meanwhile.
// A result held in the output register waits for rsp ready while the next
// request is accepted; that request stalls at its result until the register frees.
`include "chained_hash_map_top_defines.svh"

module chained_hash_map_top (
   input logic      clock,
   input logic      reset,
   chm_req_if.sink   req_bus,
   chm_rsp_if.source rsp_bus
);

   chm_pkg::chm_cmd_type cmd;
   chm_pkg::chm_sts_type sts;

   // sequencer: init sweep, lookup, chain walk, update, result
   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // bucket heads, entry pool RAMs, free list and result register
   chm_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_bus.command),
      .req_key         (req_bus.key),
      .req_value       (req_bus.value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_found_value (rsp_bus.found_value),
      .rsp_entry_count (rsp_bus.entry_count),
      .cmd             (cmd),
      .sts             (sts)
   );

   // a request occupies the block; no second accept straight after
   `CHM_ASSERT_NEXT(a_one_at_a_time, req_bus.valid && req_bus.ready, !req_bus.ready)
   // the result register is never overwritten while still held
   `CHM_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !(rsp_bus.valid && !rsp_bus.ready))
   // the pool never holds more than it has
   `CHM_ASSERT_NOW(a_count_bound, 1'b1, sts.count <= chm_pkg::COUNT_W'(chm_pkg::POOL_ENTRIES))

endmodule

FILE: hw/rtl/chm_ram.sv
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/chm_ctrl.sv
module chm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  chm_pkg::chm_sts_type sts,
   output chm_pkg::chm_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_LOOKUP, ST_HEAD, ST_WALK,
      ST_DECIDE, ST_PUT_WR, ST_REM_FREE, ST_FINISH
   } state_type;

   state_type              state_ff;
   chm_pkg::chm_status_type code_ff;
   logic                   found_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.rsp_code  = code_ff;
      cmd.rsp_found = found_ff;
      case (state_ff)
         ST_INIT:     cmd.init_step = 1'b1;
         ST_IDLE:     cmd.load_req  = req_valid;
         ST_LOOKUP:   cmd.head_rd   = (sts.command != chm_pkg::CMD_NONE) && !sts.key_zero;
         ST_HEAD:     cmd.head_take = 1'b1;
         ST_WALK: begin
            cmd.take_hit = sts.key_match;
            cmd.walk     = !sts.key_match && !sts.link_nil;
         end
         ST_DECIDE: begin
            cmd.put_rd = (sts.command == chm_pkg::CMD_PUT) && !sts.hit && !sts.free_nil;
            cmd.unlink = (sts.command == chm_pkg::CMD_REMOVE) && sts.hit;
         end
         ST_PUT_WR:   cmd.put_wr   = 1'b1;
         ST_REM_FREE: cmd.rem_free = 1'b1;
         ST_FINISH:   cmd.rsp_load = !sts.rsp_busy;
         default:     cmd.rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         code_ff  <= chm_pkg::STATUS_OK;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_INIT: begin
               if (sts.init_done) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               found_ff <= 1'b0;
               code_ff  <= chm_pkg::STATUS_OK;
               if (sts.command == chm_pkg::CMD_NONE) begin
                  state_ff <= ST_FINISH;
               end else if (sts.key_zero) begin
                  code_ff  <= chm_pkg::STATUS_KEY_ZERO;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_HEAD;
               end
            end
            ST_HEAD: begin
               state_ff <= sts.head_nil ? ST_DECIDE : ST_WALK;
            end
            ST_WALK: begin
               if (sts.key_match || sts.link_nil) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               state_ff <= ST_FINISH;
               case (sts.command)
                  chm_pkg::CMD_PUT: begin
                     if (sts.hit) code_ff <= chm_pkg::STATUS_EXISTS;
                     else if (sts.free_nil) code_ff <= chm_pkg::STATUS_FULL;
                     else state_ff <= ST_PUT_WR;
                  end
                  chm_pkg::CMD_GET: begin
                     if (sts.hit) found_ff <= 1'b1;
                     else code_ff <= chm_pkg::STATUS_NOT_FOUND;
                  end
                  chm_pkg::CMD_REMOVE: begin
                     if (sts.hit) state_ff <= ST_REM_FREE;
                     else code_ff <= chm_pkg::STATUS_NOT_FOUND;
                  end
                  default: code_ff <= chm_pkg::STATUS_OK;
               endcase
            end
            ST_PUT_WR:   state_ff <= ST_FINISH;
            ST_REM_FREE: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (!sts.rsp_busy) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_INIT;
         endcase
      end
   end

endmodule

FILE: hw/rtl/chm_datapath.sv
module chm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_command,
   input  logic [chm_pkg::KEY_BITS-1:0]   req_key,
   input  logic [chm_pkg::VALUE_BITS-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [chm_pkg::VALUE_BITS-1:0] rsp_found_value,
   output logic [chm_pkg::COUNT_W-1:0]    rsp_entry_count,
   input  chm_pkg::chm_cmd_type           cmd,
   output chm_pkg::chm_sts_type           sts
);

   localparam int LW = chm_pkg::LINK_W;
   localparam int PW = chm_pkg::POOL_W;
   localparam int BW = chm_pkg::BUCKET_W;
   localparam int KW = chm_pkg::KEY_BITS;
   localparam int VW = chm_pkg::VALUE_BITS;

   logic [chm_pkg::INIT_W-1:0] init_ff;
   logic [1:0]                 command_ff;
   logic [KW-1:0]              key_ff;
   logic [VW-1:0]              value_ff;
   logic [LW-1:0]              cur_ff, prev_ff, head_ff, free_ff, hit_next_ff;
   logic [VW-1:0]              hit_value_ff;
   logic                       hit_ff;
   logic [chm_pkg::COUNT_W-1:0] count_ff;
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_status_ff;
   logic [VW-1:0]              rsp_found_ff;
   logic [chm_pkg::COUNT_W-1:0] rsp_count_ff;

   // memory ports
   logic          bkt_we, link_we, ent_we;
   logic [BW-1:0] bkt_addr;
   logic [PW-1:0] link_addr, ent_addr;
   logic [LW-1:0] bkt_wdata, bkt_rdata, link_wdata, link_rdata;
   logic [KW-1:0] key_rdata;
   logic [VW-1:0] value_rdata;
   logic [chm_pkg::INIT_CW-1:0] init_ext;

   assign init_ext = chm_pkg::INIT_CW'(init_ff);

   always_comb begin
      bkt_we     = 1'b0;
      bkt_addr   = key_ff[BW-1:0];
      bkt_wdata  = chm_pkg::NIL;
      link_we    = 1'b0;
      link_addr  = free_ff[PW-1:0];
      link_wdata = free_ff;
      ent_we     = 1'b0;
      ent_addr   = free_ff[PW-1:0];
      if (cmd.init_step) begin
         bkt_addr   = BW'(init_ff);
         bkt_we     = init_ext < chm_pkg::INIT_CW'(chm_pkg::BUCKETS);
         link_addr  = PW'(init_ff);
         link_we    = init_ext < chm_pkg::INIT_CW'(chm_pkg::POOL_ENTRIES);
         link_wdata = LW'(init_ext + 1'b1);
      end else if (cmd.head_take) begin
         link_addr = bkt_rdata[PW-1:0];
         ent_addr  = bkt_rdata[PW-1:0];
      end else if (cmd.walk) begin
         link_addr = link_rdata[PW-1:0];
         ent_addr  = link_rdata[PW-1:0];
      end else if (cmd.put_wr) begin
         bkt_we     = 1'b1;
         bkt_wdata  = free_ff;
         link_we    = 1'b1;
         link_wdata = head_ff;
         ent_we     = 1'b1;
      end else if (cmd.unlink) begin
         bkt_we     = chm_pkg::is_nil(prev_ff);
         bkt_wdata  = hit_next_ff;
         link_we    = !chm_pkg::is_nil(prev_ff);
         link_addr  = prev_ff[PW-1:0];
         link_wdata = hit_next_ff;
      end else if (cmd.rem_free) begin
         link_we    = 1'b1;
         link_addr  = cur_ff[PW-1:0];
         link_wdata = free_ff;
      end
   end

   chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::BUCKETS)) u_bucket (
      .clock(clock), .we(bkt_we), .addr(bkt_addr), .wdata(bkt_wdata), .rdata(bkt_rdata)
   );
   chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_link (
      .clock(clock), .we(link_we), .addr(link_addr), .wdata(link_wdata), .rdata(link_rdata)
   );
   chm_ram #(.WIDTH(KW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_key (
      .clock(clock), .we(ent_we), .addr(ent_addr), .wdata(key_ff), .rdata(key_rdata)
   );
   chm_ram #(.WIDTH(VW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_value (
      .clock(clock), .we(ent_we), .addr(ent_addr), .wdata(value_ff), .rdata(value_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.init_step) init_ff <= init_ff + 1'b1;
         if (cmd.head_take) hit_ff <= 1'b0;
         if (cmd.take_hit)  hit_ff <= 1'b1;
         if (cmd.put_wr) begin
            free_ff  <= chm_pkg::clamp(link_rdata);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.rem_free) begin
            free_ff <= cur_ff;
            if (count_ff != '0) count_ff <= count_ff - 1'b1;
         end
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_command;
         key_ff     <= req_key;
         value_ff   <= req_value;
      end
      if (cmd.head_take) begin
         cur_ff  <= chm_pkg::clamp(bkt_rdata);
         head_ff <= chm_pkg::clamp(bkt_rdata);
         prev_ff <= chm_pkg::NIL;
      end
      if (cmd.walk) begin
         prev_ff <= cur_ff;
         cur_ff  <= chm_pkg::clamp(link_rdata);
      end
      if (cmd.take_hit) begin
         hit_value_ff <= value_rdata;
         hit_next_ff  <= chm_pkg::clamp(link_rdata);
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_found_ff  <= cmd.rsp_found ? hit_value_ff : '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      sts.init_done = init_ff == chm_pkg::INIT_W'(chm_pkg::INIT_DEPTH - 1);
      sts.command   = chm_pkg::chm_command_type'(command_ff);
      sts.key_zero  = key_ff == '0;
      sts.head_nil  = chm_pkg::is_nil(bkt_rdata);
      sts.key_match = key_rdata == key_ff;
      sts.link_nil  = chm_pkg::is_nil(link_rdata);
      sts.hit       = hit_ff;
      sts.prev_nil  = chm_pkg::is_nil(prev_ff);
      sts.free_nil  = chm_pkg::is_nil(free_ff);
      sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
      sts.count     = count_ff;
   end

endmodule

FILE: test/chained_hash_map_top_test.sv
module chained_hash_map_top_test;
   import chm_pkg::*;

   // Expected response of one request.
   typedef struct packed {
      chm_status_type     status;
      logic [31:0]        found_value;
      logic [COUNT_W-1:0] entry_count;
   } map_answer_type;

   // Scoreboard: keeps its own copy of the chained table and the queue of answers due.
   class map_scoreboard;
      logic [LINK_W-1:0]  heads[BUCKETS];
      logic [31:0]        keys[POOL_ENTRIES];
      logic [31:0]        vals[POOL_ENTRIES];
      logic [LINK_W-1:0]  links[POOL_ENTRIES];
      logic [LINK_W-1:0]  free_top;
      logic [COUNT_W-1:0] held;
      map_answer_type     due[$];
      int                 errors;

      function new();
         for (int i = 0; i < BUCKETS; i++) heads[i] = NIL;
         for (int i = 0; i < POOL_ENTRIES; i++) begin
            keys[i] = '0;
            vals[i] = '0;
            links[i] = LINK_W'(i + 1);
         end
         free_top = '0;
         held = '0;
         errors = 0;
      endfunction

      // Apply an accepted request and queue its answer.
      function void note_request(chm_command_type cmd, logic [31:0] key, logic [31:0] val);
         map_answer_type a;
         int b, cur, prev, hit, prev_hit, steps, e;
         a.status = STATUS_OK;
         a.found_value = '0;
         if (cmd != CMD_NONE && key == 0) begin
            a.status = STATUS_KEY_ZERO;
         end else if (cmd != CMD_NONE) begin
            b = key % BUCKETS;
            cur = heads[b];
            prev = POOL_ENTRIES;
            hit = POOL_ENTRIES;
            prev_hit = POOL_ENTRIES;
            steps = 0;
            while (cur < POOL_ENTRIES && steps < POOL_ENTRIES && hit == POOL_ENTRIES) begin
               if (keys[cur] == key) begin
                  hit = cur;
                  prev_hit = prev;
               end else begin
                  prev = cur;
                  cur = links[cur];
                  steps++;
               end
            end
            case (cmd)
               CMD_PUT: begin
                  if (hit != POOL_ENTRIES) a.status = STATUS_EXISTS;
                  else if (free_top >= NIL) a.status = STATUS_FULL;
                  else begin
                     e = free_top;
                     free_top = links[e];
                     keys[e] = key;
                     vals[e] = val;
                     links[e] = heads[b];
                     heads[b] = LINK_W'(e);
                     held++;
                  end
               end
               CMD_GET: begin
                  if (hit == POOL_ENTRIES) a.status = STATUS_NOT_FOUND;
                  else a.found_value = vals[hit];
               end
               default: begin
                  if (hit == POOL_ENTRIES) a.status = STATUS_NOT_FOUND;
                  else begin
                     if (prev_hit == POOL_ENTRIES) heads[b] = links[hit];
                     else links[prev_hit] = links[hit];
                     links[hit] = free_top;
                     free_top = LINK_W'(hit);
                     if (held > 0) held--;
                  end
               end
            endcase
         end
         a.entry_count = held;
         due.push_back(a);
      endfunction

      function void check_response(logic [2:0] st, logic [31:0] fv, logic [COUNT_W-1:0] cnt);
         map_answer_type a;
         if (due.size() == 0) begin
            $display("%0t: unexpected response status %0d value %h count %0d",
                     $time, st, fv, cnt);
            errors++;
            return;
         end
         a = due.pop_front();
         if (st !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, a.status, st);
            errors++;
         end
         if (fv !== a.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, a.found_value, fv);
            errors++;
         end
         if (cnt !== a.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, a.entry_count, cnt);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   chm_req_if req_bus();
   chm_rsp_if rsp_bus();

   chained_hash_map_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   map_scoreboard board = new();

   bit quiet_phase = 1'b0;   // last part of the run: no idling on either side
   bit long_hold   = 1'b0;   // receiver holds off for a long stretch
   int cycle_count = 0;

   localparam int CYCLE_LIMIT = 400000;

   // Keys used in well-formed sequences: a few buckets share several keys so chains grow.
   logic [31:0] key_pool[64];

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_PUT;
      req_bus.key     = '0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Scoreboard sampling at the edge, from values set before it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_request(chm_command_type'(req_bus.command), req_bus.key, req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_response(rsp_bus.status, rsp_bus.found_value, rsp_bus.entry_count);
      end
   end

   // Response side: random stall bursts, plus one long hold-off counted here.
   initial begin : rsp_side
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request and wait until it is accepted.
   task automatic send_request(chm_command_type cmd, logic [31:0] key, logic [31:0] val);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.key     <= key;
      req_bus.value   <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom();
         default: return key_pool[$urandom_range(0, 63)];
      endcase
   endfunction

   initial begin : req_side
      chm_command_type cmd;
      logic [31:0] k;
      for (int i = 0; i < 64; i++) begin
         // Eight buckets, eight keys each; the upper 22 bits are random, the low bits pick the bucket.
         key_pool[i] = {22'($urandom_range(1, 32'h3F_FFFF)), 10'(i % 8)};
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: key zero on each command, unused command, hits and misses, chains.
      send_request(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'h0, 32'h0);
      send_request(CMD_REMOVE, 32'h0, 32'h0);
      send_request(CMD_NONE, 32'h0, 32'h1234);
      send_request(CMD_GET, 32'h1, 32'h0);
      send_request(CMD_REMOVE, 32'h1, 32'h0);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_PUT, 32'h0000_0400, 32'h0);
      send_request(CMD_PUT, 32'h0000_0800, 32'hA5A5_5A5A);
      send_request(CMD_PUT, 32'h0000_0C00, 32'h5A5A_A5A5);
      send_request(CMD_REMOVE, 32'h0000_0800, 32'h0);   // middle of chain
      send_request(CMD_GET, 32'h0000_0400, 32'h0);
      send_request(CMD_REMOVE, 32'h0000_0C00, 32'h0);   // chain head
      send_request(CMD_REMOVE, 32'h0000_0400, 32'h0);   // last entry
      send_request(CMD_GET, 32'h0000_0C00, 32'h0);
      send_request(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_all();

      // Fill the pool to full, with the receiver held off so the block backs up.
      long_hold = 1'b1;
      for (int i = 1; i <= POOL_ENTRIES + 2; i++)
         send_request(CMD_PUT, {22'($urandom_range(0, 32'h3F_FFFF)), 10'(i % 16)} | 32'h1,
                      $urandom());
      drain_all();
      // Empty it again by removing exactly what is held.
      for (int b = 0; b < BUCKETS; b++)
         while (board.heads[b] < NIL) begin
            k = board.keys[board.heads[b]];
            send_request(CMD_REMOVE, k, $urandom());
            drain_all();
         end

      // Random part: mostly pool keys, some noise.
      for (int n = 0; n < 1120; n++) begin
         if (n == 920) quiet_phase = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: cmd = CMD_PUT;
            4, 5, 6:    cmd = CMD_GET;
            7, 8:       cmd = CMD_REMOVE;
            default:    cmd = CMD_NONE;
         endcase
         send_request(cmd, pick_key(), $urandom());
      end
      drain_all();
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
